### design/ssp_pkg.sv
// shared constants and types for the swept segment proximity test
package ssp_pkg;

    // default coordinate width of the input fields
    localparam int COORD_BITS_DEF = 20;

    // fraction bits of the projection parameter
    localparam int T_FRAC_BITS = 16;

    // width and reset value of the squared hit radius register
    localparam int RADIUS_BITS = 32;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(512 * 512);

    // how the projection parameter is chosen for one item
    typedef struct packed {
        logic zero;  // degenerate segment or target at or behind the start
        logic one;   // target at or beyond the end
    } t_tsel;

endpackage

### design/swept_segment_proximity_test.sv
// top level of the swept segment proximity test
// Swept segment proximity test. Each item gives a moving object's previous
// and current position and a target point; the block reports whether the
// target lies within the squared hit radius of the swept segment. busy is
// always low: a new item is taken every cycle, and the item's hit appears on
// o_hit with o_done high for one cycle. It passes 4 front stages (differences,
// products, sums, classification), 16 division stages that form the 16-bit
// projection one quotient bit each, and 4 back stages (scaling, nearest
// offset, squares, compare). The receiver cannot stall; results must be
// taken when o_done is high. The user writes the radius register with i_cfg_we
// and i_cfg_wdata while no item is in flight; the block does not enforce it.
module swept_segment_proximity_test #(
    parameter int COORD_BITS = ssp_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cfg_we,
    input  logic [ssp_pkg::RADIUS_BITS-1:0]    i_cfg_wdata,
    input  logic signed [COORD_BITS-1:0]       i_start_x,
    input  logic signed [COORD_BITS-1:0]       i_start_y,
    input  logic signed [COORD_BITS-1:0]       i_end_x,
    input  logic signed [COORD_BITS-1:0]       i_end_y,
    input  logic signed [COORD_BITS-1:0]       i_target_x,
    input  logic signed [COORD_BITS-1:0]       i_target_y,
    output logic                               o_done,
    output logic                               o_hit
);
    import ssp_pkg::*;

    localparam int LW = 2 * COORD_BITS + 2;

    logic [RADIUS_BITS-1:0] r_radius;
    logic                   n_accept;

    logic                       s_v   [0:T_FRAC_BITS];
    logic [LW-1:0]              s_rem [0:T_FRAC_BITS];
    logic [LW-1:0]              s_den [0:T_FRAC_BITS];
    logic [T_FRAC_BITS-1:0]     s_q   [0:T_FRAC_BITS];
    t_tsel                      s_sel [0:T_FRAC_BITS];
    logic signed [COORD_BITS:0] s_dx  [0:T_FRAC_BITS];
    logic signed [COORD_BITS:0] s_dy  [0:T_FRAC_BITS];
    logic signed [COORD_BITS:0] s_px  [0:T_FRAC_BITS];
    logic signed [COORD_BITS:0] s_py  [0:T_FRAC_BITS];

    // the pipeline never holds off an item
    assign busy     = 1'b0;
    assign n_accept = start && !busy;

    // squared hit radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    // front stages
    ssp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (n_accept),
        .i_start_x  (i_start_x),
        .i_start_y  (i_start_y),
        .i_end_x    (i_end_x),
        .i_end_y    (i_end_y),
        .i_target_x (i_target_x),
        .i_target_y (i_target_y),
        .o_valid    (s_v[0]),
        .o_num      (s_rem[0]),
        .o_den      (s_den[0]),
        .o_sel      (s_sel[0]),
        .o_dx       (s_dx[0]),
        .o_dy       (s_dy[0]),
        .o_px       (s_px[0]),
        .o_py       (s_py[0])
    );

    assign s_q[0] = '0;

    // division pipeline, one quotient bit per stage
    for (genvar g = 0; g < T_FRAC_BITS; g++) begin : g_div
        ssp_div_stage #(
            .COORD_BITS (COORD_BITS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_v[g]),
            .i_rem   (s_rem[g]),
            .i_den   (s_den[g]),
            .i_q     (s_q[g]),
            .i_sel   (s_sel[g]),
            .i_dx    (s_dx[g]),
            .i_dy    (s_dy[g]),
            .i_px    (s_px[g]),
            .i_py    (s_py[g]),
            .o_valid (s_v[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_den   (s_den[g+1]),
            .o_q     (s_q[g+1]),
            .o_sel   (s_sel[g+1]),
            .o_dx    (s_dx[g+1]),
            .o_dy    (s_dy[g+1]),
            .o_px    (s_px[g+1]),
            .o_py    (s_py[g+1])
        );
    end

    // back stages
    ssp_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_v[T_FRAC_BITS]),
        .i_q      (s_q[T_FRAC_BITS]),
        .i_sel    (s_sel[T_FRAC_BITS]),
        .i_dx     (s_dx[T_FRAC_BITS]),
        .i_dy     (s_dy[T_FRAC_BITS]),
        .i_px     (s_px[T_FRAC_BITS]),
        .i_py     (s_py[T_FRAC_BITS]),
        .i_radius (r_radius),
        .o_done   (o_done),
        .o_hit    (o_hit)
    );

endmodule

### design/ssp_front.sv
// front stages: differences, products, dot and length, range classification
module ssp_front #(
    parameter int COORD_BITS = ssp_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [COORD_BITS-1:0]   i_start_x,
    input  logic signed [COORD_BITS-1:0]   i_start_y,
    input  logic signed [COORD_BITS-1:0]   i_end_x,
    input  logic signed [COORD_BITS-1:0]   i_end_y,
    input  logic signed [COORD_BITS-1:0]   i_target_x,
    input  logic signed [COORD_BITS-1:0]   i_target_y,
    output logic                           o_valid,
    output logic        [2*COORD_BITS+1:0] o_num,
    output logic        [2*COORD_BITS+1:0] o_den,
    output ssp_pkg::t_tsel                 o_sel,
    output logic signed [COORD_BITS:0]     o_dx,
    output logic signed [COORD_BITS:0]     o_dy,
    output logic signed [COORD_BITS:0]     o_px,
    output logic signed [COORD_BITS:0]     o_py
);
    import ssp_pkg::*;

    localparam int DW   = COORD_BITS + 1;      // difference width
    localparam int PW   = 2 * COORD_BITS + 2;  // product width
    localparam int LW   = 2 * COORD_BITS + 2;  // squared length width, unsigned
    localparam int DOTW = 2 * COORD_BITS + 3;  // dot product width, signed

    logic                 r_v1, r_v2, r_v3, r_v4;
    logic signed [DW-1:0] r_dx1, r_dy1, r_px1, r_py1;
    logic signed [DW-1:0] r_dx2, r_dy2, r_px2, r_py2;
    logic signed [DW-1:0] r_dx3, r_dy3, r_px3, r_py3;
    logic signed [DW-1:0] r_dx4, r_dy4, r_px4, r_py4;
    logic signed [PW-1:0] r_dxx, r_dyy, r_pdx, r_pdy;
    logic [LW-1:0]        r_len2;
    logic signed [DOTW-1:0] r_dot;
    logic [LW-1:0]        r_num, r_den;
    t_tsel                r_sel;

    logic                 n_degen, n_neg, n_ge;
    t_tsel                n_sel;

    // valid bits travel with the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // stage 1: segment direction and target offset from the start
    always_ff @(posedge i_clk) begin
        r_dx1 <= DW'(i_end_x) - DW'(i_start_x);
        r_dy1 <= DW'(i_end_y) - DW'(i_start_y);
        r_px1 <= DW'(i_target_x) - DW'(i_start_x);
        r_py1 <= DW'(i_target_y) - DW'(i_start_y);
    end

    // stage 2: the four products
    always_ff @(posedge i_clk) begin
        r_dxx <= PW'(r_dx1) * PW'(r_dx1);
        r_dyy <= PW'(r_dy1) * PW'(r_dy1);
        r_pdx <= PW'(r_px1) * PW'(r_dx1);
        r_pdy <= PW'(r_py1) * PW'(r_dy1);
        r_dx2 <= r_dx1;
        r_dy2 <= r_dy1;
        r_px2 <= r_px1;
        r_py2 <= r_py1;
    end

    // stage 3: squared length and dot product
    always_ff @(posedge i_clk) begin
        r_len2 <= LW'(r_dxx) + LW'(r_dyy);
        r_dot  <= DOTW'(r_pdx) + DOTW'(r_pdy);
        r_dx3  <= r_dx2;
        r_dy3  <= r_dy2;
        r_px3  <= r_px2;
        r_py3  <= r_py2;
    end

    // stage 4: classify the projection and seed the divider
    always_comb begin
        n_degen  = (r_len2[LW-1:1] == '0);
        n_neg    = r_dot[DOTW-1] || (r_dot == '0);
        n_ge     = (r_dot >= $signed({1'b0, r_len2}));
        n_sel.zero = n_degen || n_neg;
        n_sel.one  = !n_sel.zero && n_ge;
    end

    always_ff @(posedge i_clk) begin
        r_sel <= n_sel;
        r_num <= (n_sel.zero || n_sel.one) ? '0 : r_dot[LW-1:0];
        r_den <= r_len2;
        r_dx4 <= r_dx3;
        r_dy4 <= r_dy3;
        r_px4 <= r_px3;
        r_py4 <= r_py3;
    end

    assign o_valid = r_v4;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_sel   = r_sel;
    assign o_dx    = r_dx4;
    assign o_dy    = r_dy4;
    assign o_px    = r_px4;
    assign o_py    = r_py4;

endmodule

### design/ssp_div_stage.sv
// one restoring division step of the projection quotient, registered
module ssp_div_stage #(
    parameter int COORD_BITS = ssp_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic        [2*COORD_BITS+1:0]    i_rem,
    input  logic        [2*COORD_BITS+1:0]    i_den,
    input  logic        [ssp_pkg::T_FRAC_BITS-1:0] i_q,
    input  ssp_pkg::t_tsel                    i_sel,
    input  logic signed [COORD_BITS:0]        i_dx,
    input  logic signed [COORD_BITS:0]        i_dy,
    input  logic signed [COORD_BITS:0]        i_px,
    input  logic signed [COORD_BITS:0]        i_py,
    output logic                              o_valid,
    output logic        [2*COORD_BITS+1:0]    o_rem,
    output logic        [2*COORD_BITS+1:0]    o_den,
    output logic        [ssp_pkg::T_FRAC_BITS-1:0] o_q,
    output ssp_pkg::t_tsel                    o_sel,
    output logic signed [COORD_BITS:0]        o_dx,
    output logic signed [COORD_BITS:0]        o_dy,
    output logic signed [COORD_BITS:0]        o_px,
    output logic signed [COORD_BITS:0]        o_py
);
    import ssp_pkg::*;

    localparam int LW = 2 * COORD_BITS + 2;

    logic                   r_v;
    logic [LW-1:0]          r_rem, r_den;
    logic [T_FRAC_BITS-1:0] r_q;
    t_tsel                  r_sel;
    logic signed [COORD_BITS:0] r_dx, r_dy, r_px, r_py;

    logic [LW:0]            n_sh, n_diff;
    logic                   n_ge;

    // shift in one bit and try the subtraction
    always_comb begin
        n_sh   = {i_rem, 1'b0};
        n_diff = n_sh - {1'b0, i_den};
        n_ge   = (n_sh >= {1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_ge ? n_diff[LW-1:0] : n_sh[LW-1:0];
        r_q   <= {i_q[T_FRAC_BITS-2:0], n_ge};
        r_den <= i_den;
        r_sel <= i_sel;
        r_dx  <= i_dx;
        r_dy  <= i_dy;
        r_px  <= i_px;
        r_py  <= i_py;
    end

    assign o_valid = r_v;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_q     = r_q;
    assign o_sel   = r_sel;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_px    = r_px;
    assign o_py    = r_py;

endmodule

### design/ssp_back.sv
// back stages: nearest point, squared distance and radius compare
module ssp_back #(
    parameter int COORD_BITS = ssp_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic        [ssp_pkg::T_FRAC_BITS-1:0] i_q,
    input  ssp_pkg::t_tsel                    i_sel,
    input  logic signed [COORD_BITS:0]        i_dx,
    input  logic signed [COORD_BITS:0]        i_dy,
    input  logic signed [COORD_BITS:0]        i_px,
    input  logic signed [COORD_BITS:0]        i_py,
    input  logic        [ssp_pkg::RADIUS_BITS-1:0] i_radius,
    output logic                              o_done,
    output logic                              o_hit
);
    import ssp_pkg::*;

    localparam int TW  = T_FRAC_BITS + 2;           // signed parameter, holds one
    localparam int MW  = COORD_BITS + 1 + TW;       // direction times parameter
    localparam int DW  = COORD_BITS + 3;            // distance component
    localparam int SQ  = 2 * DW;                    // squared component
    localparam int SW  = SQ + 1;                    // squared distance
    localparam int CW  = (SW > RADIUS_BITS) ? SW : RADIUS_BITS;

    logic                 r_v1, r_v2, r_v3, r_v4;
    logic signed [MW-1:0] r_mx, r_my;
    logic signed [COORD_BITS:0] r_px1, r_py1;
    logic signed [DW-1:0] r_distx, r_disty;
    logic signed [SQ-1:0] r_sqx, r_sqy;
    logic                 r_hit;

    logic signed [TW-1:0] n_t;
    logic [SW-1:0]        n_dist2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // pick the clamped projection parameter
    always_comb begin
        if (i_sel.zero) begin
            n_t = '0;
        end else if (i_sel.one) begin
            n_t = TW'(1) <<< T_FRAC_BITS;
        end else begin
            n_t = $signed({2'b00, i_q});
        end
    end

    // stage 1: scale the direction by the parameter
    always_ff @(posedge i_clk) begin
        r_mx  <= MW'(i_dx) * MW'(n_t);
        r_my  <= MW'(i_dy) * MW'(n_t);
        r_px1 <= i_px;
        r_py1 <= i_py;
    end

    // stage 2: offset from the nearest point, floor of the scaled direction
    always_ff @(posedge i_clk) begin
        r_distx <= DW'(r_px1) - DW'(r_mx >>> T_FRAC_BITS);
        r_disty <= DW'(r_py1) - DW'(r_my >>> T_FRAC_BITS);
    end

    // stage 3: squares
    always_ff @(posedge i_clk) begin
        r_sqx <= SQ'(r_distx) * SQ'(r_distx);
        r_sqy <= SQ'(r_disty) * SQ'(r_disty);
    end

    // stage 4: sum and compare with the radius
    assign n_dist2 = SW'(unsigned'(r_sqx)) + SW'(unsigned'(r_sqy));

    always_ff @(posedge i_clk) begin
        r_hit <= (CW'(n_dist2) <= CW'(i_radius));
    end

    assign o_done = r_v4;
    assign o_hit  = r_hit;

endmodule

### bench/swept_segment_proximity_test_tb.sv
// self-checking testbench for the swept segment proximity test
module swept_segment_proximity_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = ssp_pkg::COORD_BITS_DEF;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_PHASES = 6;
    localparam int QUIET_PHASE = 3;
    localparam int DRAIN_CYCLES = 30;
    localparam int STALL_LIMIT = 500;
    localparam int NUM_PROBES = 19;

    typedef logic signed [CW-1:0] t_coord;

    // one directed item: segment, target, and a hit value where it is obvious
    typedef struct packed {
        int sx;
        int sy;
        int ex;
        int ey;
        int tx;
        int ty;
        bit pinned;
        bit hit;
    } t_probe;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic                           i_cfg_we;
    logic [ssp_pkg::RADIUS_BITS-1:0] i_cfg_wdata;
    t_coord                         i_start_x;
    t_coord                         i_start_y;
    t_coord                         i_end_x;
    t_coord                         i_end_y;
    t_coord                         i_target_x;
    t_coord                         i_target_y;
    logic                           o_done;
    logic                           o_hit;

    logic [ssp_pkg::RADIUS_BITS-1:0] radius_sq;
    bit                             pending_hits[$];
    int                             error_count = 0;

    // directed items, checked with the default radius of 512 squared
    t_probe corner_probes [NUM_PROBES] = '{
        '{0, 0, 0, 0, 0, 0, 1'b1, 1'b1},
        '{0, 0, 0, 0, 512, 0, 1'b1, 1'b1},
        '{0, 0, 0, 0, 0, -513, 1'b1, 1'b0},
        '{0, 0, 1, 0, 513, 0, 1'b1, 1'b0},
        '{0, 0, 0, -1, 0, -512, 1'b1, 1'b1},
        '{0, 0, 1000, 0, -512, 0, 1'b1, 1'b1},
        '{0, 0, 1000, 0, -513, 0, 1'b1, 1'b0},
        '{0, 0, 1000, 0, 1512, 0, 1'b1, 1'b1},
        '{0, 0, 1000, 0, 1513, 0, 1'b1, 1'b0},
        '{0, 0, 1000, 0, 500, 512, 1'b0, 1'b0},
        '{0, 0, 1000, 0, 500, 513, 1'b0, 1'b0},
        '{524287, 524287, 524287, 524287, 524287, 524287, 1'b1, 1'b1},
        '{-524288, -524288, -524288, -524288, 524287, 524287, 1'b1, 1'b0},
        '{-524288, -524288, 524287, 524287, 524287, -524288, 1'b0, 1'b0},
        '{524287, 0, -524288, 0, 0, 100, 1'b0, 1'b0},
        '{-524288, 524287, 524287, -524288, 0, 0, 1'b0, 1'b0},
        '{-1, -1, -2, -2, -300, -300, 1'b0, 1'b0},
        '{100, -200, -3000, 4000, -1500, 1900, 1'b0, 1'b0},
        '{-7, -9, 123456, -654, 123456, -654, 1'b0, 1'b0}
    };

    swept_segment_proximity_test dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_target_x  (i_target_x),
        .i_target_y  (i_target_y),
        .o_done      (o_done),
        .o_hit       (o_hit)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // whether the squared distance from target to the nearest point of the segment is within r
    function automatic bit hit_within_radius(input t_coord sx, input t_coord sy,
                                             input t_coord ex, input t_coord ey,
                                             input t_coord tx, input t_coord ty,
                                             input logic [ssp_pkg::RADIUS_BITS-1:0] r);
        longint dx, dy, px, py, len2, dot, t, ox, oy, dist2;
        dx = longint'(ex) - longint'(sx);
        dy = longint'(ey) - longint'(sy);
        px = longint'(tx) - longint'(sx);
        py = longint'(ty) - longint'(sy);
        len2 = dx * dx + dy * dy;
        if (len2 <= 1) begin
            ox = px;
            oy = py;
        end else begin
            dot = px * dx + py * dy;
            // projection parameter in fixed point with 16 fraction bits, clamped to the segment
            if (dot <= 0)
                t = 0;
            else if (dot >= len2)
                t = longint'(1) <<< ssp_pkg::T_FRAC_BITS;
            else
                t = (dot <<< ssp_pkg::T_FRAC_BITS) / len2;
            ox = px - ((dx * t) >>> ssp_pkg::T_FRAC_BITS);
            oy = py - ((dy * t) >>> ssp_pkg::T_FRAC_BITS);
        end
        dist2 = ox * ox + oy * oy;
        return dist2 <= longint'(r);
    endfunction

    // symmetric random offset in [-span, span]
    function automatic longint jitter(input int unsigned span);
        return longint'($urandom_range(0, 2 * span)) - longint'(span);
    endfunction

    // present one item and hold it until the block takes it
    task automatic send_item(input t_coord sx, input t_coord sy, input t_coord ex,
                             input t_coord ey, input t_coord tx, input t_coord ty,
                             input bit pinned, input bit pinned_hit);
        i_start_x  <= sx;
        i_start_y  <= sy;
        i_end_x    <= ex;
        i_end_y    <= ey;
        i_target_x <= tx;
        i_target_y <= ty;
        start      <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_hits.push_back(pinned ? pinned_hit :
                               hit_within_radius(sx, sy, ex, ey, tx, ty, radius_sq));
    endtask

    // occasional sender gap before the next item
    task automatic maybe_idle(input bit allow);
        if (allow && $urandom_range(0, 99) < 3) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // stop sending and wait for every outstanding hit
    task automatic drain_hits();
        start <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
    endtask

    // radius write, only with the pipeline empty
    task automatic set_radius(input logic [ssp_pkg::RADIUS_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        radius_sq = value;
    endtask

    // random item: mostly segments with targets near them, some noise
    task automatic send_random_item();
        longint sx, sy, dx, dy, tx, ty;
        int unsigned mode;
        int f;
        sx = $urandom;
        sy = $urandom;
        dx = $urandom;
        dy = $urandom;
        tx = $urandom;
        ty = $urandom;
        mode = $urandom_range(0, 9);
        if (mode == 2) begin
            // degenerate or near-degenerate segment, target around the start
            dx = 0;
            dy = 0;
            case ($urandom_range(0, 5))
                1: dx = 1;
                2: dx = -1;
                3: dy = 1;
                4: dy = -1;
                5: begin
                    dx = jitter(1);
                    dy = jitter(1);
                end
                default: ;
            endcase
            tx = sx + jitter((32'd1 << $urandom_range(0, 19)) - 1);
            ty = sy + jitter((32'd1 << $urandom_range(0, 19)) - 1);
        end else if (mode > 2) begin
            // target along the extended segment plus an offset of random scale
            dx = jitter((32'd1 << $urandom_range(1, 19)) - 1);
            dy = jitter((32'd1 << $urandom_range(1, 19)) - 1);
            f = int'($urandom_range(0, 2048)) - 512;
            tx = sx + (longint'(f) * dx) / 1024 + jitter((32'd1 << $urandom_range(0, 19)) - 1);
            ty = sy + (longint'(f) * dy) / 1024 + jitter((32'd1 << $urandom_range(0, 19)) - 1);
        end
        send_item(CW'(sx), CW'(sy), CW'(sx + dx), CW'(sy + dy), CW'(tx), CW'(ty),
                  1'b0, 1'b0);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_hits.size() == 0) begin
                $error("hit: result with no item pending, got %0b", o_hit);
                error_count++;
            end else begin
                if (o_hit !== pending_hits[0]) begin
                    $error("hit: expected %0b, got %0b", pending_hits[0], o_hit);
                    error_count++;
                end
                void'(pending_hits.pop_front());
            end
        end
    end

    // watchdog on cycles with no item or result taken
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // stimulus
    initial begin
        logic [ssp_pkg::RADIUS_BITS-1:0] phase_radius [NUM_PHASES];
        int i;
        int p;
        int n;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_start_x   <= '0;
        i_start_y   <= '0;
        i_end_x     <= '0;
        i_end_y     <= '0;
        i_target_x  <= '0;
        i_target_y  <= '0;
        radius_sq = ssp_pkg::RADIUS_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items at the reset radius
        for (i = 0; i < NUM_PROBES; i++) begin
            maybe_idle(1'b1);
            send_item(CW'(corner_probes[i].sx), CW'(corner_probes[i].sy),
                      CW'(corner_probes[i].ex), CW'(corner_probes[i].ey),
                      CW'(corner_probes[i].tx), CW'(corner_probes[i].ty),
                      corner_probes[i].pinned, corner_probes[i].hit);
        end
        drain_hits();

        // random phases, one radius each, extremes included
        phase_radius[0] = '1;
        phase_radius[1] = '0;
        phase_radius[2] = $urandom_range(1, 1 << 20);
        phase_radius[3] = ssp_pkg::RADIUS_RESET;
        phase_radius[4] = $urandom;
        phase_radius[5] = 64 * 64;
        for (p = 0; p < NUM_PHASES; p++) begin
            set_radius(phase_radius[p]);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                maybe_idle(p != QUIET_PHASE);
                send_random_item();
            end
            drain_hits();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_hits.size() != 0) begin
            $error("hit: %0d results never arrived", pending_hits.size());
            error_count++;
        end
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
design/ssp_pkg.sv
design/ssp_front.sv
design/ssp_div_stage.sv
design/ssp_back.sv
design/swept_segment_proximity_test.sv
bench/swept_segment_proximity_test_tb.sv
